/* sv/dual_motor_limit_interlock_core_macros.svh */
// assertion helpers for the interlock core
// both expect clk and rst_n in the scope of use
`ifndef DUAL_MOTOR_LIMIT_INTERLOCK_CORE_MACROS_SVH
`define DUAL_MOTOR_LIMIT_INTERLOCK_CORE_MACROS_SVH

// same-cycle implication
`define DMLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dmli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dmli_pkg;

  // result outcome codes
  typedef enum logic [1:0] {
    OUTCOME_APPLIED   = 2'd0,
    OUTCOME_OTHER     = 2'd1,
    OUTCOME_BAD_CHAN  = 2'd2,
    OUTCOME_LIMIT_EVT = 2'd3
  } outcome_t;

  // config register indexes
  typedef enum logic [2:0] {
    CFG_OWN_INSTANCE  = 3'd0,
    CFG_LEFT_FWD_FN   = 3'd1,
    CFG_LEFT_REV_FN   = 3'd2,
    CFG_RIGHT_FWD_FN  = 3'd3,
    CFG_RIGHT_REV_FN  = 3'd4
  } cfg_idx_t;

  localparam logic [7:0]         NONE_FUNCTION = 8'd255;
  localparam logic signed [15:0] DUTY_RAW_MIN  = 16'sh8000;
  localparam logic signed [15:0] DUTY_NEG_MAX  = -16'sd32767;
  localparam logic [15:0]        DEADBAND      = 16'd33;
  localparam logic [15:0]        COUNT_MAX     = 16'hFFFF;

  // pwm magnitude of a stored duty, zero inside the deadband
  function automatic logic [14:0] magnitude_of(input logic signed [15:0] d);
    logic [15:0] m;
    m = d[15] ? 16'(-d) : 16'(d);
    if (m < DEADBAND) begin
      m = 16'd0;
    end
    return m[14:0];
  endfunction

endpackage

`default_nettype wire

/* sv/dual_motor_limit_interlock_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-channel H-bridge duty controller with limit-switch interlock. Each input
// transfer is a speed command (in_command = 0) or a limit sensor event
// (in_command = 1), and each one yields exactly one result transfer holding the
// full output picture: both PWM magnitudes and directions, enable and limit
// flags, the outcome code and the two saturating counters. It takes one item per
// clock unless the output stalls; an item passes the input register, then the
// result register, with all decode, clamp and interlock logic between. Config
// (own instance, four limit function ids, 255 = unused) is written via the cfg_
// port (always ready) by the user only while no item is in flight, unenforced.
module dual_motor_limit_interlock_core (
  input  wire               clk,
  input  wire               rst_n,
  // command / event channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_command,
  input  wire  [2:0]        in_target_instance,
  input  wire  [1:0]        in_channel,
  input  wire               in_enable,
  input  wire  signed [15:0] in_duty,
  input  wire  [7:0]        in_sensor_function,
  input  wire               in_sensor_state,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic [14:0]       out_left_magnitude,
  output logic              out_left_forward,
  output logic [14:0]       out_right_magnitude,
  output logic              out_right_forward,
  output logic [1:0]        out_enabled_flags,
  output logic [3:0]        out_limit_flags,
  output logic [1:0]        out_outcome,
  output logic [15:0]       out_command_total,
  output logic [15:0]       out_error_total,
  // configuration write channel
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [2:0]        cfg_index,
  input  wire  [7:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0] own_r;
  logic [7:0] fwd_fn_r [2];   // forward limit function id per channel
  logic [7:0] rev_fn_r [2];   // reverse limit function id per channel

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r       <= 3'd0;
      fwd_fn_r[0] <= dmli_pkg::NONE_FUNCTION;
      fwd_fn_r[1] <= dmli_pkg::NONE_FUNCTION;
      rev_fn_r[0] <= dmli_pkg::NONE_FUNCTION;
      rev_fn_r[1] <= dmli_pkg::NONE_FUNCTION;
    end else if (cfg_valid && cfg_ready) begin
      case (dmli_pkg::cfg_idx_t'(cfg_index))
        dmli_pkg::CFG_OWN_INSTANCE: own_r       <= cfg_data[2:0];
        dmli_pkg::CFG_LEFT_FWD_FN:  fwd_fn_r[0] <= cfg_data;
        dmli_pkg::CFG_LEFT_REV_FN:  rev_fn_r[0] <= cfg_data;
        dmli_pkg::CFG_RIGHT_FWD_FN: fwd_fn_r[1] <= cfg_data;
        dmli_pkg::CFG_RIGHT_REV_FN: rev_fn_r[1] <= cfg_data;
        default: ;  // indexes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the result register whenever the result
  // register is empty or being drained this cycle
  // ---------------------------------------------------------------------------
  logic s1_vld_r;
  logic out_vld_r;
  logic advance;
  logic take_in;

  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign take_in  = in_valid && !in_stall;

  // input register payload
  logic               s1_cmd_r;
  logic [2:0]         s1_tgt_r;
  logic [1:0]         s1_ch_r;
  logic               s1_en_r;
  logic signed [15:0] s1_duty_r;
  logic [7:0]         s1_func_r;
  logic               s1_sstate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (take_in) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_cmd_r    <= in_command;
      s1_tgt_r    <= in_target_instance;
      s1_ch_r     <= in_channel;
      s1_en_r     <= in_enable;
      s1_duty_r   <= in_duty;
      s1_func_r   <= in_sensor_function;
      s1_sstate_r <= in_sensor_state;
    end
  end

  // ---------------------------------------------------------------------------
  // channel state
  // ---------------------------------------------------------------------------
  logic signed [15:0] duty_r [2];
  logic [1:0]         dir_r;     // 1 forward
  logic [1:0]         en_r;
  logic [1:0]         flim_r;
  logic [1:0]         rlim_r;
  logic [15:0]        acc_cnt_r;
  logic [15:0]        err_cnt_r;

  logic signed [15:0] duty_nxt [2];
  logic [1:0]         dir_nxt;
  logic [1:0]         en_nxt;
  logic [1:0]         flim_nxt;
  logic [1:0]         rlim_nxt;
  logic [15:0]        acc_cnt_nxt;
  logic [15:0]        err_cnt_nxt;
  dmli_pkg::outcome_t outcome_nxt;

  logic               ch_sel;
  logic signed [15:0] duty_clamped;

  assign ch_sel       = s1_ch_r[0];
  // -32768 has no positive twin in Q1.15, pull it in to -32767
  assign duty_clamped = (s1_duty_r == dmli_pkg::DUTY_RAW_MIN) ? dmli_pkg::DUTY_NEG_MAX
                                                              : s1_duty_r;

  always_comb begin
    logic signed [15:0] cmd_d;
    logic               cmd_fwd;

    duty_nxt    = duty_r;
    dir_nxt     = dir_r;
    en_nxt      = en_r;
    flim_nxt    = flim_r;
    rlim_nxt    = rlim_r;
    acc_cnt_nxt = acc_cnt_r;
    err_cnt_nxt = err_cnt_r;
    outcome_nxt = dmli_pkg::OUTCOME_APPLIED;
    cmd_d       = 16'sd0;
    cmd_fwd     = 1'b1;

    if (!s1_cmd_r) begin
      // speed command
      if (s1_tgt_r != own_r) begin
        outcome_nxt = dmli_pkg::OUTCOME_OTHER;
      end else if (s1_ch_r[1]) begin
        if (err_cnt_r != dmli_pkg::COUNT_MAX) begin
          err_cnt_nxt = err_cnt_r + 16'd1;
        end
        outcome_nxt = dmli_pkg::OUTCOME_BAD_CHAN;
      end else begin
        // disable drives zero, which reads as forward
        cmd_d   = s1_en_r ? duty_clamped : 16'sd0;
        cmd_fwd = !cmd_d[15];
        // interlock: no motion into an active limit, direction still follows
        if ((cmd_fwd && flim_r[ch_sel]) || (!cmd_fwd && rlim_r[ch_sel])) begin
          cmd_d = 16'sd0;
        end
        duty_nxt[ch_sel] = cmd_d;
        dir_nxt[ch_sel]  = cmd_fwd;
        en_nxt[ch_sel]   = s1_en_r;
        if (acc_cnt_r != dmli_pkg::COUNT_MAX) begin
          acc_cnt_nxt = acc_cnt_r + 16'd1;
        end
      end
    end else begin
      // limit event, every matching register is updated
      outcome_nxt = dmli_pkg::OUTCOME_LIMIT_EVT;
      for (int i = 0; i < 2; i++) begin
        if (fwd_fn_r[i] != dmli_pkg::NONE_FUNCTION && s1_func_r == fwd_fn_r[i]) begin
          flim_nxt[i] = s1_sstate_r;
          if (s1_sstate_r && duty_nxt[i] > 16'sd0) begin
            duty_nxt[i] = 16'sd0;
            dir_nxt[i]  = 1'b1;
          end
        end
        if (rev_fn_r[i] != dmli_pkg::NONE_FUNCTION && s1_func_r == rev_fn_r[i]) begin
          rlim_nxt[i] = s1_sstate_r;
          if (s1_sstate_r && duty_nxt[i] < 16'sd0) begin
            duty_nxt[i] = 16'sd0;
            dir_nxt[i]  = 1'b1;
          end
        end
      end
    end
  end

  // state commits together with the result register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r[0] <= 16'sd0;
      duty_r[1] <= 16'sd0;
      dir_r     <= 2'b00;
      en_r      <= 2'b00;
      flim_r    <= 2'b00;
      rlim_r    <= 2'b00;
      acc_cnt_r <= 16'd0;
      err_cnt_r <= 16'd0;
    end else if (advance) begin
      duty_r    <= duty_nxt;
      dir_r     <= dir_nxt;
      en_r      <= en_nxt;
      flim_r    <= flim_nxt;
      rlim_r    <= rlim_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      err_cnt_r <= err_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [14:0]        out_lmag_r;
  logic [14:0]        out_rmag_r;
  logic [1:0]         out_dir_r;
  logic [1:0]         out_en_r;
  logic [3:0]         out_lim_r;
  dmli_pkg::outcome_t out_outcome_r;
  logic [15:0]        out_acc_r;
  logic [15:0]        out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_lmag_r    <= dmli_pkg::magnitude_of(duty_nxt[0]);
      out_rmag_r    <= dmli_pkg::magnitude_of(duty_nxt[1]);
      out_dir_r     <= dir_nxt;
      out_en_r      <= en_nxt;
      out_lim_r     <= {rlim_nxt[1], flim_nxt[1], rlim_nxt[0], flim_nxt[0]};
      out_outcome_r <= outcome_nxt;
      out_acc_r     <= acc_cnt_nxt;
      out_err_r     <= err_cnt_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_left_magnitude  = out_lmag_r;
  assign out_left_forward    = out_dir_r[0];
  assign out_right_magnitude = out_rmag_r;
  assign out_right_forward   = out_dir_r[1];
  assign out_enabled_flags   = out_en_r;
  assign out_limit_flags     = out_lim_r;
  assign out_outcome         = out_outcome_r;
  assign out_command_total   = out_acc_r;
  assign out_error_total     = out_err_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "dual_motor_limit_interlock_core_macros.svh"

  // state only moves when an item reaches the result register
  `DMLI_ASSERT_NEXT(a_count_hold, !advance, $stable(acc_cnt_r) && $stable(err_cnt_r), "counter moved without a transfer")
  // interlock: a channel never holds a duty that drives into an active limit
  `DMLI_ASSERT_NOW(a_left_interlock, flim_r[0] || rlim_r[0], !(flim_r[0] && duty_r[0] > 16'sd0) && !(rlim_r[0] && duty_r[0] < 16'sd0), "left channel drives into active limit")
  `DMLI_ASSERT_NOW(a_right_interlock, flim_r[1] || rlim_r[1], !(flim_r[1] && duty_r[1] > 16'sd0) && !(rlim_r[1] && duty_r[1] < 16'sd0), "right channel drives into active limit")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  // command kinds and motor channels as carried on the input channel
  localparam logic       CMD_SPEED       = 1'b0;
  localparam logic       CMD_LIMIT_EVENT = 1'b1;
  localparam logic [1:0] CH_LEFT         = 2'd0;
  localparam logic [1:0] CH_RIGHT        = 2'd1;
  localparam logic [1:0] CH_INVALID_2    = 2'd2;
  localparam logic [1:0] CH_INVALID_3    = 2'd3;

  typedef struct {
    logic               command;
    logic [2:0]         target;
    logic [1:0]         chan;
    logic               enable;
    logic signed [15:0] duty;
    logic [7:0]         sensor_fn;
    logic               sensor_on;
  } motor_cmd_t;

  typedef struct {
    logic [14:0]          left_mag;
    logic                 left_fwd;
    logic [14:0]          right_mag;
    logic                 right_fwd;
    logic [1:0]           enabled;
    logic [3:0]           limits;
    dmli_pkg::outcome_t   outcome;
    logic [15:0]          cmd_total;
    logic [15:0]          err_total;
  } motor_picture_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic [2:0]         in_target_instance = '0;
  logic [1:0]         in_channel = '0;
  logic               in_enable = 1'b0;
  logic signed [15:0] in_duty = '0;
  logic [7:0]         in_sensor_function = '0;
  logic               in_sensor_state = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_left_magnitude;
  logic        out_left_forward;
  logic [14:0] out_right_magnitude;
  logic        out_right_forward;
  logic [1:0]  out_enabled_flags;
  logic [3:0]  out_limit_flags;
  logic [1:0]  out_outcome;
  logic [15:0] out_command_total;
  logic [15:0] out_error_total;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  dual_motor_limit_interlock_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_target_instance  (in_target_instance),
    .in_channel          (in_channel),
    .in_enable           (in_enable),
    .in_duty             (in_duty),
    .in_sensor_function  (in_sensor_function),
    .in_sensor_state     (in_sensor_state),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_left_magnitude  (out_left_magnitude),
    .out_left_forward    (out_left_forward),
    .out_right_magnitude (out_right_magnitude),
    .out_right_forward   (out_right_forward),
    .out_enabled_flags   (out_enabled_flags),
    .out_limit_flags     (out_limit_flags),
    .out_outcome         (out_outcome),
    .out_command_total   (out_command_total),
    .out_error_total     (out_error_total),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the interlock state and its register settings
  logic signed [15:0] duty_q [2];
  logic               dir_q [2];
  logic               en_q [2];
  logic               fwd_lim_q [2];
  logic               rev_lim_q [2];
  logic [15:0]        ok_count;
  logic [15:0]        err_count;
  logic [2:0]         own_inst;
  logic [7:0]         lim_fn [4];

  motor_picture_t predicted_pictures [$];

  // run bookkeeping
  bit calm = 1'b0;
  int holdoff_len = 0;
  int holdoff_ticket = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int settings_loaded = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [14:0] pwm_level(input logic signed [15:0] d);
    logic [15:0] a;
    a = d[15] ? 16'(-d) : 16'(d);
    return (a < dmli_pkg::DEADBAND) ? 15'd0 : a[14:0];
  endfunction

  // clamp, pick direction from sign, zero the duty when driving into a limit
  function automatic void set_duty(input int ch, input logic signed [15:0] d);
    logic signed [15:0] v;
    logic               fwd;
    v = (d == dmli_pkg::DUTY_RAW_MIN) ? dmli_pkg::DUTY_NEG_MAX : d;
    fwd = ~v[15];
    if ((fwd && fwd_lim_q[ch]) || (!fwd && rev_lim_q[ch])) begin
      v = 16'sd0;
    end
    dir_q[ch] = fwd;
    duty_q[ch] = v;
  endfunction

  function automatic motor_picture_t next_picture(input motor_cmd_t c);
    motor_picture_t p;
    if (c.command == CMD_SPEED) begin
      if (c.target != own_inst) begin
        p.outcome = dmli_pkg::OUTCOME_OTHER;
      end else if (c.chan != CH_LEFT && c.chan != CH_RIGHT) begin
        if (err_count != dmli_pkg::COUNT_MAX) err_count++;
        p.outcome = dmli_pkg::OUTCOME_BAD_CHAN;
      end else begin
        set_duty(int'(c.chan[0]), c.enable ? c.duty : 16'sd0);
        en_q[c.chan[0]] = c.enable;
        if (ok_count != dmli_pkg::COUNT_MAX) ok_count++;
        p.outcome = dmli_pkg::OUTCOME_APPLIED;
      end
    end else begin
      // forward then reverse per channel, left first; a shared id hits all
      for (int ch = 0; ch < 2; ch++) begin
        if (lim_fn[2*ch] != dmli_pkg::NONE_FUNCTION && c.sensor_fn == lim_fn[2*ch]) begin
          fwd_lim_q[ch] = c.sensor_on;
          if (c.sensor_on && duty_q[ch] > 16'sd0) set_duty(ch, 16'sd0);
        end
        if (lim_fn[2*ch+1] != dmli_pkg::NONE_FUNCTION && c.sensor_fn == lim_fn[2*ch+1]) begin
          rev_lim_q[ch] = c.sensor_on;
          if (c.sensor_on && duty_q[ch] < 16'sd0) set_duty(ch, 16'sd0);
        end
      end
      p.outcome = dmli_pkg::OUTCOME_LIMIT_EVT;
    end
    p.left_mag  = pwm_level(duty_q[0]);
    p.left_fwd  = dir_q[0];
    p.right_mag = pwm_level(duty_q[1]);
    p.right_fwd = dir_q[1];
    p.enabled   = {en_q[1], en_q[0]};
    p.limits    = {rev_lim_q[1], fwd_lim_q[1], rev_lim_q[0], fwd_lim_q[0]};
    p.cmd_total = ok_count;
    p.err_total = err_count;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders, ignored fields get random content
  // ---------------------------------------------------------------------------

  function automatic motor_cmd_t speed_cmd(input logic [2:0] tgt, input logic [1:0] ch,
                                           input logic en, input logic signed [15:0] d);
    motor_cmd_t c;
    c.command   = CMD_SPEED;
    c.target    = tgt;
    c.chan      = ch;
    c.enable    = en;
    c.duty      = d;
    c.sensor_fn = 8'($urandom);
    c.sensor_on = 1'($urandom);
    return c;
  endfunction

  function automatic motor_cmd_t limit_evt(input logic [7:0] fn, input logic on);
    motor_cmd_t c;
    c.command   = CMD_LIMIT_EVENT;
    c.target    = 3'($urandom);
    c.chan      = 2'($urandom);
    c.enable    = 1'($urandom);
    c.duty      = 16'($urandom);
    c.sensor_fn = fn;
    c.sensor_on = on;
    return c;
  endfunction

  // mostly commands for this instance on real channels and events on configured ids
  function automatic motor_cmd_t random_item();
    logic signed [15:0] d;
    logic [2:0]         tgt;
    logic [1:0]         ch;
    logic [7:0]         fn;
    case ($urandom_range(3))
      0: d = 16'($urandom);
      1: d = 16'($urandom_range(80)) - 16'sd40;
      2: d = $urandom_range(1) ? 16'sh7FFF :
             ($urandom_range(1) ? dmli_pkg::DUTY_RAW_MIN : dmli_pkg::DUTY_NEG_MAX);
      default: d = 16'($urandom_range(2000)) - 16'sd1000;
    endcase
    if ($urandom_range(99) < 65) begin
      tgt = ($urandom_range(99) < 85) ? own_inst : 3'($urandom);
      ch = ($urandom_range(99) < 88) ? 2'($urandom_range(1)) : 2'($urandom);
      return speed_cmd(tgt, ch, 1'($urandom_range(99) < 85), d);
    end
    fn = ($urandom_range(99) < 75) ? lim_fn[$urandom_range(3)] : 8'($urandom);
    return limit_evt(fn, 1'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back transfers; payload holds while stalled
  task automatic send_item(input motor_cmd_t c);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= c.command;
    in_target_instance <= c.target;
    in_channel         <= c.chan;
    in_enable          <= c.enable;
    in_duty            <= c.duty;
    in_sensor_function <= c.sensor_fn;
    in_sensor_state    <= c.sensor_on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_pictures.push_back(next_picture(c));
    items_sent++;
  endtask

  // sender goes quiet until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_pictures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [2:0] inst, input logic [7:0] lf,
                               input logic [7:0] lr, input logic [7:0] rf,
                               input logic [7:0] rr);
    dmli_pkg::cfg_idx_t idx [5];
    logic [7:0]         val [5];
    idx = '{dmli_pkg::CFG_OWN_INSTANCE, dmli_pkg::CFG_LEFT_FWD_FN, dmli_pkg::CFG_LEFT_REV_FN,
            dmli_pkg::CFG_RIGHT_FWD_FN, dmli_pkg::CFG_RIGHT_REV_FN};
    val = '{{5'd0, inst}, lf, lr, rf, rr};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        dmli_pkg::CFG_OWN_INSTANCE: own_inst = val[i][2:0];
        dmli_pkg::CFG_LEFT_FWD_FN:  lim_fn[0] = val[i];
        dmli_pkg::CFG_LEFT_REV_FN:  lim_fn[1] = val[i];
        dmli_pkg::CFG_RIGHT_FWD_FN: lim_fn[2] = val[i];
        default:                    lim_fn[3] = val[i];
      endcase
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // receiver: random stalls, plus long hold-offs counted here on request
  int holdoff_left = 0;
  int holdoff_seen = 0;
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_ticket) begin
      holdoff_seen = holdoff_ticket;
      holdoff_left = holdoff_len;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    motor_picture_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_pictures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing outstanding", results_seen);
        end
      end else begin
        want = predicted_pictures.pop_front();
        check_field("left_magnitude", 16'(want.left_mag), 16'(out_left_magnitude));
        check_field("left_forward", 16'(want.left_fwd), 16'(out_left_forward));
        check_field("right_magnitude", 16'(want.right_mag), 16'(out_right_magnitude));
        check_field("right_forward", 16'(want.right_fwd), 16'(out_right_forward));
        check_field("enabled_flags", 16'(want.enabled), 16'(out_enabled_flags));
        check_field("limit_flags", 16'(want.limits), 16'(out_limit_flags));
        check_field("outcome", 16'(want.outcome), 16'(out_outcome));
        check_field("command_total", want.cmd_total, out_command_total);
        check_field("error_total", want.err_total, out_error_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register reset values: instance 0, no limit ids configured
  task automatic test_power_on_defaults();
    send_item(speed_cmd(3'd0, CH_LEFT, 1'b1, 16'sh7FFF));
    send_item(speed_cmd(3'd0, CH_RIGHT, 1'b1, dmli_pkg::DUTY_RAW_MIN)); // clamps to -32767
    send_item(speed_cmd(3'd0, CH_LEFT, 1'b1, 16'sd32));         // inside deadband
    send_item(speed_cmd(3'd0, CH_RIGHT, 1'b1, -16'sd33));       // just outside deadband
    send_item(speed_cmd(3'd0, CH_LEFT, 1'b1, 16'sd0));          // zero counts as forward
    send_item(speed_cmd(3'd0, CH_RIGHT, 1'b0, -16'sd5));        // disable
    send_item(speed_cmd(3'd7, CH_LEFT, 1'b1, 16'sd100));        // other instance
    send_item(speed_cmd(3'd0, CH_INVALID_2, 1'b1, 16'sd100));
    send_item(speed_cmd(3'd0, CH_INVALID_3, 1'b0, -16'sd1));
    send_item(limit_evt(dmli_pkg::NONE_FUNCTION, 1'b1));        // unused id never matches
  endtask

  // id 0 shared by left forward and right reverse
  task automatic test_limit_interlock();
    wait_drained();
    load_settings(3'd7, 8'd0, 8'd254, 8'd9, 8'd0);
    send_item(speed_cmd(3'd7, CH_LEFT, 1'b1, 16'sd1000));
    send_item(speed_cmd(3'd7, CH_RIGHT, 1'b1, -16'sd1000));
    send_item(limit_evt(8'd0, 1'b1));                           // stops both channels
    send_item(speed_cmd(3'd7, CH_LEFT, 1'b1, 16'sd500));        // blocked forward
    send_item(speed_cmd(3'd7, CH_LEFT, 1'b1, -16'sd500));       // reverse still free
    send_item(limit_evt(8'd254, 1'b1));
    send_item(speed_cmd(3'd7, CH_LEFT, 1'b1, -16'sd1));         // blocked, keeps reverse
    send_item(limit_evt(8'd254, 1'b0));
    send_item(limit_evt(8'd0, 1'b0));
    send_item(speed_cmd(3'd7, CH_RIGHT, 1'b1, 16'sd20));
    send_item(limit_evt(8'd9, 1'b1));
  endtask

  task automatic test_random_settings();
    logic [7:0] fn [4];
    for (int s = 0; s < 6; s++) begin
      wait_drained();
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(4))
          0: fn[i] = dmli_pkg::NONE_FUNCTION;
          1: fn[i] = 8'd0;
          2: fn[i] = 8'($urandom);
          default: fn[i] = 8'($urandom_range(5));
        endcase
      end
      case (s)
        0: load_settings(3'd7, 8'd0, 8'd1, 8'd2, 8'd3);
        1: load_settings(3'd0, dmli_pkg::NONE_FUNCTION, dmli_pkg::NONE_FUNCTION, 8'd5, 8'd5);
        default: load_settings(3'($urandom), fn[0], fn[1], fn[2], fn[3]);
      endcase
      // one phase runs with no idling on either side
      calm = (s == 3);
      repeat (290) send_item(random_item());
    end
    calm = 1'b0;
  endtask

  // receiver holds off long enough to back the block up into its input
  task automatic test_backpressure();
    holdoff_len = 80;
    holdoff_ticket++;
    repeat (40) send_item(random_item());
    wait_drained();
    repeat (40) send_item(random_item());
  endtask

  initial begin
    int leftover;
    own_inst = 3'd0;
    ok_count = '0;
    err_count = '0;
    for (int i = 0; i < 4; i++) lim_fn[i] = dmli_pkg::NONE_FUNCTION;
    for (int i = 0; i < 2; i++) begin
      duty_q[i] = 16'sd0;
      dir_q[i] = 1'b0;
      en_q[i] = 1'b0;
      fwd_lim_q[i] = 1'b0;
      rev_lim_q[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_limit_interlock();
    test_random_settings();
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk);
    leftover = predicted_pictures.size();
    $display("%0d transfers sent under %0d register settings, %0d results compared",
             items_sent, settings_loaded, results_seen);
    $display("limits, deadband, clamping, bad channels and back-pressure exercised");
    if (mismatches == 0 && leftover == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog: a run that has not finished by this time is reported as NOT OK
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
